>>> rtl/hsv2rgb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hsv2rgb_pkg;

  // Field widths of the two channels.
  localparam int HUE_W = 15;
  localparam int PCT_W = 7;
  localparam int CH_W  = 8;

  // Arithmetic constants.
  localparam int SECTOR_DEG = 60;     // degrees per hue sector
  localparam int PCT_FULL   = 100;    // one hundred percent
  localparam int FULL_SCALE = 255;    // channel full scale
  localparam int PAIR_ODD   = 15;     // two sectors are PAIR_ODD << (frac bits + PAIR_SHIFT)
  localparam int PAIR_SHIFT = 3;

  // After the hue fraction bits are shifted out, the common denominator is
  // 10000 * 60. The scaled numerator always stays below 2**28, so one
  // reciprocal with a single correction step covers the whole range.
  localparam int DEN_RED     = 600000;
  localparam int NUM_W       = 28;
  localparam int RECIP       = 447;   // floor(2**28 / 600000)
  localparam int RECIP_W     = 9;
  localparam int QUOT_W      = 9;

  localparam int CHANNELS = 3;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] saturation;
    logic [PCT_W-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // What a channel carries before the offset is added: zero, X or chroma.
  typedef enum logic [1:0] {
    ROLE_ZERO = 2'd0,
    ROLE_X    = 2'd1,
    ROLE_C    = 2'd2
  } role_t;

  // Index 0 is red, 1 is green, 2 is blue.
  typedef role_t [CHANNELS-1:0] role_set_t;

  function automatic role_set_t sector_roles(sector_t sec);
    role_set_t roles;
    unique case (sec)
      SEC_RED_YEL: roles = {ROLE_ZERO, ROLE_X,    ROLE_C};
      SEC_YEL_GRN: roles = {ROLE_ZERO, ROLE_C,    ROLE_X};
      SEC_GRN_CYN: roles = {ROLE_X,    ROLE_C,    ROLE_ZERO};
      SEC_CYN_BLU: roles = {ROLE_C,    ROLE_X,    ROLE_ZERO};
      SEC_BLU_MAG: roles = {ROLE_C,    ROLE_ZERO, ROLE_X};
      default:     roles = {ROLE_X,    ROLE_ZERO, ROLE_C};
    endcase
    return roles;
  endfunction

endpackage

`default_nettype wire

>>> rtl/hsv_to_rgb_converter.sv
`timescale 1ns / 1ps
`default_nettype none

// HSV to RGB converter.
// The input channel (in_valid, in_ready, in_data) takes one item per pixel: a hue in
// units of 1/2**HUE_FRAC_BITS degree, a saturation and a value in whole percent.
// The result channel (out_valid, out_ready, out_data) returns one item per input item,
// red, green and blue as floor(255 * (channel + m)), clamped to 0..255.
// The datapath is a nine-stage pipeline: an item passes stage registers 0 to 8 in order,
// and its result stays on out_data in the stage-8 register until out_ready takes it.
// One item enters every cycle while the receiver keeps out_ready high;
// the rate is set by the handshakes alone, as no state links one pixel to the next.
// Each stage has its own valid bit and loads whenever it is empty or the stage after it
// moves, so bubbles are squeezed out and the block keeps taking items while a result
// waits in the output register. When the receiver stalls, items pile up stage by stage
// and in_ready falls only once all nine stages hold an item; nothing is lost or repeated.
// A synchronous reset (rst_n low) empties the pipeline; results in flight are dropped.
module hsv_to_rgb_converter #(
  parameter int HUE_FRAC_BITS = 6
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  hsv2rgb_pkg::hsv_t   in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output hsv2rgb_pkg::rgb_t   out_data
);
  import hsv2rgb_pkg::*;

  localparam int F    = HUE_FRAC_BITS;
  localparam int P    = SECTOR_DEG * (2 ** F);        // hue units per sector
  localparam int P2   = 2 * P;
  localparam int AW   = $clog2(P + 1);                // position inside a sector pair
  localparam int DW   = (HUE_W > AW + 1) ? HUE_W : AW + 1;
  localparam int XW   = HUE_W - F - PAIR_SHIFT;       // hue in units of 2**(F+3)
  localparam int KX   = XW + 4;
  localparam int MX   = (2 ** KX) / PAIR_ODD;         // reciprocal of PAIR_ODD
  localparam int SAW  = PCT_W + AW;                   // saturation times position
  localparam int WSW  = PCT_W + AW + 2;               // signed channel weight
  localparam int VWW  = PCT_W + WSW - 1;              // value times weight
  localparam int TW   = VWW + CH_W;                   // times full scale
  localparam int NST  = 9;

  // Stage handshake: a stage loads when it is empty or its successor loads.
  logic [NST-1:0] vld_r;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !vld_r[NST-1] || out_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // Stage 0: estimate of hue / (2P) from a reciprocal multiply.
  logic [HUE_W-1:0]  h0_r;
  logic [PCT_W-1:0]  s0_r, v0_r;
  logic [XW-1:0]     qx0_r;
  logic [XW+KX-1:0]  xm_prod;

  assign xm_prod = (XW+KX)'(in_data.hue[HUE_W-1:F+PAIR_SHIFT]) * (XW+KX)'(MX);

  // Stage 1: the estimate is low by at most one; fix it up.
  logic [HUE_W-1:0]  h1_r;
  logic [PCT_W-1:0]  s1_r, v1_r;
  logic [XW-1:0]     q1_r;
  logic [XW+3:0]     q15;
  logic [XW+3:0]     xrem;
  logic [XW-1:0]     q1_nxt;

  always_comb begin
    q15    = (XW+4)'(qx0_r) * (XW+4)'(PAIR_ODD);
    xrem   = (XW+4)'(h0_r[HUE_W-1:F+PAIR_SHIFT]) - q15;
    q1_nxt = qx0_r + XW'(xrem >= (XW+4)'(PAIR_ODD));
  end

  // Stage 2: remainder within the sector pair, position a = P - |r2 - P|,
  // and the sector. Hue beyond the last sector keeps the last sector.
  logic [AW-1:0]     a2_r;
  sector_t           sec2_r;
  logic [PCT_W-1:0]  s2_r, v2_r;
  logic [XW+3:0]     q15b;
  logic [HUE_W+3:0]  q2p;
  logic [DW-1:0]     r2;
  logic              upper;
  logic [AW-1:0]     a2_nxt;
  sector_t           sec2_nxt;

  always_comb begin
    q15b   = (XW+4)'(q1_r) * (XW+4)'(PAIR_ODD);
    q2p    = {q15b, {(F + PAIR_SHIFT){1'b0}}};
    r2     = DW'(h1_r - q2p[HUE_W-1:0]);
    upper  = r2 >= DW'(P);
    a2_nxt = upper ? AW'(DW'(P2) - r2) : AW'(r2);
    if (q1_r >= XW'(3)) begin
      sec2_nxt = SEC_MAG_RED;
    end else begin
      sec2_nxt = sector_t'({q1_r[1:0], upper});
    end
  end

  // Stage 3: each channel's position (0, a or P) times saturation, and the
  // shared offset term (100 - S) * P.
  logic [SAW-1:0]          sa3_r [CHANNELS];
  logic signed [WSW-1:0]   mterm3_r;
  logic [PCT_W-1:0]        v3_r;
  logic [SAW-1:0]          sa3_nxt [CHANNELS];
  logic signed [PCT_W:0]   msat;
  logic signed [WSW-1:0]   mterm3_nxt;
  role_set_t               roles;
  logic [AW-1:0]           a_sel;

  always_comb begin
    roles = sector_roles(sec2_r);
    for (int c = 0; c < CHANNELS; c++) begin
      unique case (roles[c])
        ROLE_C:  a_sel = AW'(P);
        ROLE_X:  a_sel = a2_r;
        default: a_sel = '0;
      endcase
      sa3_nxt[c] = SAW'(s2_r) * SAW'(a_sel);
    end
    msat       = $signed((PCT_W+1)'(PCT_FULL) - {1'b0, s2_r});
    mterm3_nxt = WSW'(msat) * WSW'(P);
  end

  // Stage 4: channel weight S*a + (100-S)*P, negative weights give zero.
  logic [WSW-2:0]        wp4_r [CHANNELS];
  logic [PCT_W-1:0]      v4_r;
  logic [WSW-2:0]        wp4_nxt [CHANNELS];
  logic signed [WSW-1:0] wsum;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      wsum       = $signed({2'b00, sa3_r[c]}) + mterm3_r;
      wp4_nxt[c] = wsum[WSW-1] ? '0 : wsum[WSW-2:0];
    end
  end

  // Stage 5: times value.
  logic [VWW-1:0] vw5_r [CHANNELS];

  // Stage 6: times full scale, fraction bits dropped.
  logic [NUM_W-1:0] y6_r [CHANNELS];
  logic [TW-1:0]    t6 [CHANNELS];

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      t6[c] = TW'(vw5_r[c]) * TW'(FULL_SCALE);
    end
  end

  // Stage 7: quotient estimate by reciprocal.
  logic [NUM_W-1:0]          y7_r [CHANNELS];
  logic [QUOT_W-1:0]         qa7_r [CHANNELS];
  logic [NUM_W+RECIP_W-1:0]  yr_prod [CHANNELS];

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      yr_prod[c] = (NUM_W+RECIP_W)'(y6_r[c]) * (NUM_W+RECIP_W)'(RECIP);
    end
  end

  // Stage 8: correct the quotient by one where needed and clamp to full scale.
  rgb_t              out_r;
  logic [CH_W-1:0]   chan_nxt [CHANNELS];
  logic [NUM_W-1:0]  qd [CHANNELS];
  logic [NUM_W-1:0]  yrem [CHANNELS];
  logic [QUOT_W:0]   qf [CHANNELS];

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      qd[c]   = NUM_W'(qa7_r[c]) * NUM_W'(DEN_RED);
      yrem[c] = y7_r[c] - qd[c];
      qf[c]   = {1'b0, qa7_r[c]} + (QUOT_W+1)'(yrem[c] >= NUM_W'(DEN_RED));
      chan_nxt[c] = (qf[c] > (QUOT_W+1)'(FULL_SCALE)) ? CH_W'(FULL_SCALE)
                                                       : qf[c][CH_W-1:0];
    end
  end

  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      h0_r  <= in_data.hue;
      s0_r  <= in_data.saturation;
      v0_r  <= in_data.brightness;
      qx0_r <= xm_prod[XW+KX-1:KX];
    end
    if (en[1]) begin
      h1_r <= h0_r;
      s1_r <= s0_r;
      v1_r <= v0_r;
      q1_r <= q1_nxt;
    end
    if (en[2]) begin
      a2_r   <= a2_nxt;
      sec2_r <= sec2_nxt;
      s2_r   <= s1_r;
      v2_r   <= v1_r;
    end
    if (en[3]) begin
      sa3_r    <= sa3_nxt;
      mterm3_r <= mterm3_nxt;
      v3_r     <= v2_r;
    end
    if (en[4]) begin
      wp4_r <= wp4_nxt;
      v4_r  <= v3_r;
    end
    for (int c = 0; c < CHANNELS; c++) begin
      if (en[5]) begin
        vw5_r[c] <= VWW'(v4_r) * VWW'(wp4_r[c]);
      end
      if (en[6]) begin
        y6_r[c] <= NUM_W'(t6[c] >> F);
      end
      if (en[7]) begin
        y7_r[c]  <= y6_r[c];
        qa7_r[c] <= yr_prod[c][NUM_W+RECIP_W-1:NUM_W];
      end
    end
    if (en[8]) begin
      out_r.red   <= chan_nxt[0];
      out_r.green <= chan_nxt[1];
      out_r.blue  <= chan_nxt[2];
    end
  end

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import hsv2rgb_pkg::*;

  // The block under test works with 1/64-degree hue units.
  localparam int HUE_FRAC_BITS = 6;

  // Hue units in one 60-degree sector, and the common denominator of the exact
  // rational form of every channel value (percent times percent times sector).
  localparam longint SECTOR_UNITS = longint'(SECTOR_DEG) << HUE_FRAC_BITS;
  localparam longint RGB_DENOM    = longint'(PCT_FULL) * PCT_FULL * SECTOR_UNITS;

  // The last nominal hue, just under 360 degrees.
  localparam int HUE_NOMINAL_MAX = int'(6 * SECTOR_UNITS - 1);

  // The pipeline is nine stages deep. After the last result the bench goes on
  // watching, so that any stray extra item is caught.
  localparam int TAIL_CYCLES = 30;

  // The longest sender gap and receiver stall from pick_gap are far below this,
  // so a correct run never goes anywhere near this many cycles without a handshake.
  localparam int IDLE_LIMIT = 2000;

  localparam int RANDOM_PIXELS = 500;

  // Keeps one expected color per accepted pixel, oldest first, and checks
  // each color that leaves the block against the oldest one.
  class rgb_scoreboard;
    typedef struct {
      hsv_t pixel;
      rgb_t color;
    } pending_color_t;

    pending_color_t colors_due[$];
    int errors;
    int pixels_seen;
    int colors_checked;
    int odd_pixels;

    // Floor of 255 times the channel value, clamped to the 8-bit range.
    function logic [CH_W-1:0] scale_channel(longint part_num, longint offset_num);
      longint sum_num;
      longint level;
      sum_num = part_num + offset_num;
      if (sum_num <= 0) return '0;
      level = (sum_num * FULL_SCALE) / RGB_DENOM;
      if (level > FULL_SCALE) level = FULL_SCALE;
      return level[CH_W-1:0];
    endfunction

    function rgb_t rgb_from_hsv(hsv_t px);
      longint h, s, v;
      longint sector_idx, hue_dev;
      longint chroma_num, mid_num, offset_num;
      longint r_num, g_num, b_num;
      rgb_t color;
      h = longint'(px.hue);
      s = longint'(px.saturation);
      v = longint'(px.brightness);
      sector_idx = h / SECTOR_UNITS;
      // The intermediate term follows the hue modulo two sectors, even for hues
      // at or past 360 degrees, which are not wrapped.
      hue_dev = (h % (2 * SECTOR_UNITS)) - SECTOR_UNITS;
      if (hue_dev < 0) hue_dev = -hue_dev;
      chroma_num = s * v * SECTOR_UNITS;
      mid_num    = s * v * (SECTOR_UNITS - hue_dev);
      // Saturation above full makes the offset negative.
      offset_num = v * (PCT_FULL - s) * SECTOR_UNITS;
      case (sector_idx)
        SEC_RED_YEL: begin
          r_num = chroma_num; g_num = mid_num;    b_num = 0;
        end
        SEC_YEL_GRN: begin
          r_num = mid_num;    g_num = chroma_num; b_num = 0;
        end
        SEC_GRN_CYN: begin
          r_num = 0;          g_num = chroma_num; b_num = mid_num;
        end
        SEC_CYN_BLU: begin
          r_num = 0;          g_num = mid_num;    b_num = chroma_num;
        end
        SEC_BLU_MAG: begin
          r_num = mid_num;    g_num = 0;          b_num = chroma_num;
        end
        // Magenta to red, and every hue at or past 360 degrees.
        default: begin
          r_num = chroma_num; g_num = 0;          b_num = mid_num;
        end
      endcase
      color.red   = scale_channel(r_num, offset_num);
      color.green = scale_channel(g_num, offset_num);
      color.blue  = scale_channel(b_num, offset_num);
      return color;
    endfunction

    function void note_pixel(hsv_t px);
      pending_color_t entry;
      entry.pixel = px;
      entry.color = rgb_from_hsv(px);
      colors_due.push_back(entry);
      pixels_seen++;
      if (px.hue > HUE_NOMINAL_MAX || px.saturation > PCT_FULL || px.brightness > PCT_FULL)
        odd_pixels++;
    endfunction

    function void check_color(rgb_t got);
      pending_color_t entry;
      if (colors_due.size() == 0) begin
        $error("color with no pixel waiting: red %0d green %0d blue %0d",
               got.red, got.green, got.blue);
        errors++;
        return;
      end
      entry = colors_due.pop_front();
      colors_checked++;
      if (got.red !== entry.color.red) begin
        $error("red: expected %0d, got %0d (hue %0d sat %0d val %0d)", entry.color.red,
               got.red, entry.pixel.hue, entry.pixel.saturation, entry.pixel.brightness);
        errors++;
      end
      if (got.green !== entry.color.green) begin
        $error("green: expected %0d, got %0d (hue %0d sat %0d val %0d)", entry.color.green,
               got.green, entry.pixel.hue, entry.pixel.saturation, entry.pixel.brightness);
        errors++;
      end
      if (got.blue !== entry.color.blue) begin
        $error("blue: expected %0d, got %0d (hue %0d sat %0d val %0d)", entry.color.blue,
               got.blue, entry.pixel.hue, entry.pixel.saturation, entry.pixel.brightness);
        errors++;
      end
    endfunction

    function int pending();
      return colors_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  hsv_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rgb_t out_data;

  // While this is set, neither side idles, so the pipeline runs at full rate.
  bit no_idle = 1'b0;

  rgb_scoreboard sb = new;

  hsv_to_rgb_converter #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Most gaps are zero or a few cycles; now and then a long one lets the
  // pipeline empty out or fill up completely.
  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Every handshake is observed here. All drives use nonblocking assignments
  // at the rising edge, so the values read here are the ones from before it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_pixel(in_data);
      if (out_valid && out_ready) sb.check_color(out_data);
    end
  end

  // Watchdog: a stuck handshake on either side ends the run as a failure.
  always @(posedge clk) begin
    int idle_cycles;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no item moved for %0d cycles, %0d colors still due",
                 IDLE_LIMIT, sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Receiver: alternates runs of ready with stalls of random length.
  initial begin
    int stall;
    int run_len;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      run_len = $urandom_range(1, 20);
      repeat (run_len) @(posedge clk);
    end
  end

  // Presents one pixel after an idle gap and returns at the edge where it is
  // taken. The caller must drive in_valid again in that same time step, either
  // through the next call or by lowering it, so the pixel is not taken twice.
  // A zero gap keeps valid high, which gives back-to-back pixels.
  task automatic send_pixel(hsv_t px, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
  endtask

  // Holds the input back until every color owed has come out. The check runs
  // at the falling edge, when the monitor has seen the last handshakes.
  task automatic drain_colors();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    @(posedge clk);
  endtask

  // Random pixel: mostly nominal ranges, some with saturation pinned at an end
  // and brightness often at full, and a fifth of them using every bit of every
  // field, which reaches hues past 360 degrees and percentages above 100.
  function automatic hsv_t random_pixel();
    hsv_t px;
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 2) begin
      px.hue        = HUE_W'($urandom_range(0, (1 << HUE_W) - 1));
      px.saturation = PCT_W'($urandom_range(0, (1 << PCT_W) - 1));
      px.brightness = PCT_W'($urandom_range(0, (1 << PCT_W) - 1));
    end else if (roll < 3) begin
      px.hue        = HUE_W'($urandom_range(0, HUE_NOMINAL_MAX));
      px.saturation = PCT_W'($urandom_range(0, 1) ? PCT_FULL : 0);
      px.brightness = PCT_W'($urandom_range(0, 1) ? PCT_FULL : $urandom_range(0, PCT_FULL));
    end else begin
      px.hue        = HUE_W'($urandom_range(0, HUE_NOMINAL_MAX));
      px.saturation = PCT_W'($urandom_range(0, PCT_FULL));
      px.brightness = PCT_W'($urandom_range(0, PCT_FULL));
    end
    return px;
  endfunction

  // Directed corners: both ends of every field, the first hue of each sector,
  // the last hue before the second sector and before 360 degrees, a pixel in
  // the middle of each sector, gray and black, a hue of exactly 360 degrees and
  // beyond, saturation above full (negative offset, channels clamp at zero) and
  // brightness above full (channels clamp at full scale).
  hsv_t corner_pixels[$] = '{
    {15'd0,     7'd100, 7'd100},
    {15'd23039, 7'd100, 7'd100},
    {15'd1920,  7'd100, 7'd100},
    {15'd3839,  7'd100, 7'd100},
    {15'd3840,  7'd100, 7'd100},
    {15'd7680,  7'd100, 7'd100},
    {15'd11520, 7'd100, 7'd100},
    {15'd15360, 7'd100, 7'd100},
    {15'd19200, 7'd100, 7'd100},
    {15'd5760,  7'd50,  7'd80},
    {15'd9600,  7'd75,  7'd60},
    {15'd13440, 7'd30,  7'd90},
    {15'd17280, 7'd100, 7'd50},
    {15'd21120, 7'd60,  7'd40},
    {15'd0,     7'd0,   7'd0},
    {15'd12345, 7'd0,   7'd100},
    {15'd12345, 7'd100, 7'd0},
    {15'd23040, 7'd100, 7'd100},
    {15'd26000, 7'd80,  7'd70},
    {15'd32767, 7'd127, 7'd127},
    {15'd5000,  7'd127, 7'd100},
    {15'd9000,  7'd110, 7'd60},
    {15'd14000, 7'd50,  7'd127},
    {15'd20000, 7'd0,   7'd127}
  };

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_pixels[i]) send_pixel(corner_pixels[i], pick_gap());
    // The sender waits for the pipeline to empty completely at least once.
    drain_colors();

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      // One stretch runs with neither side idling, to keep all nine stages busy.
      no_idle = (i >= 100 && i < 170);
      if (i == RANDOM_PIXELS / 2) drain_colors();
      send_pixel(random_pixel(), pick_gap());
    end
    in_valid <= 1'b0;

    drain_colors();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d pixels (%0d with hue past 360 degrees or a percentage above 100),",
             sb.pixels_seen, sb.odd_pixels);
    $display("checked %0d colors with random gaps and stalls, %0d still due.",
             sb.colors_checked, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
